FILE: hw/rtl/afow_pkg.sv
// ----------------------------------------------------------------------------
// Overlap window framer package
// Shared field widths, register indexes, the classification word that the
// front end attaches to each queued word, and helpers for the frame geometry.
// ----------------------------------------------------------------------------
package afow_pkg;

  // Field widths of the ports.
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 13;
  localparam int POS_W      = 10;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DC_BIAS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AVG_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIN_EN   = 2'd2;

  // Reset value of the bias register (mid scale of the converter).
  localparam logic [SAMPLE_W-1:0] DC_BIAS_RST = 12'd2048;

  // Hann coefficient generation constants (Q30 and Q15).
  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam longint unsigned ONE_Q30  = 64'd1 << 30;
  localparam longint unsigned COEF_MAX = 64'd32767;
  localparam int              COEF_FRAC = 15;

  // Classification of one accepted word, decided by the front end.
  typedef struct packed {
    logic seen;      // a full frame has passed, so both stores hold real data
    logic has_tail;  // an old tail sample goes out before the new one
    logic has_new;   // the new sample lands inside the FFT frame
    logic tail_wr;   // the new sample is kept for the next frame's overlap
    logic last;      // the new sample closes the frame
  } cls_t;

  // Number of samples carried over from the previous frame.
  function automatic int overlap_len(input int frame_len, input int fft_len);
    int raw;
    raw = (fft_len > frame_len) ? (fft_len - frame_len) : 0;
    return (raw > frame_len) ? frame_len : raw;
  endfunction

  // Number of new samples at the start of a frame that fall outside it.
  function automatic int skip_len(input int frame_len, input int fft_len);
    return (frame_len > fft_len) ? (frame_len - fft_len) : 0;
  endfunction

endpackage

FILE: hw/rtl/audio_frame_overlap_window_unit.sv
// ----------------------------------------------------------------------------
// Audio frame overlap window unit
// Removes the converter bias, optionally averages with the previous frame,
// builds overlapping FFT frames and applies an optional Hann window.
//
//   Channel   Direction  Handshake               Word
//   -------   ---------  ----------------------  ------------------------------
//   in        input      in_valid_i/in_ready_o   raw_sample_i
//   out       output     out_valid_o/out_ready_i position_o, level_o,
//                                                frame_last_o
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample in the overlap part of the frame yields two output words, others
// at most one; all leave through the single output register, so an overlap
// sample holds the back end while both of its words are pending.
// Reset needs no clearing pass: both stores read as zero until a full frame
// has gone through. A two-entry queue lets input and output stall separately.
// ----------------------------------------------------------------------------
module audio_frame_overlap_window_unit #(
  parameter int FRAME_LEN = 736,
  parameter int FFT_LEN   = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [afow_pkg::SAMPLE_W-1:0]         raw_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [afow_pkg::POS_W-1:0]            position_o,
  output logic signed [afow_pkg::LEVEL_W-1:0]   level_o,
  output logic                                  frame_last_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [afow_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [afow_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int FIDX_W  = $clog2(FRAME_LEN);
  localparam int LEVEL_W = afow_pkg::LEVEL_W;
  localparam int CLS_W   = $bits(afow_pkg::cls_t);
  localparam int ENT_W   = CLS_W + FIDX_W + LEVEL_W;

  // Configuration registers.
  logic [afow_pkg::SAMPLE_W-1:0] dc_bias_q, dc_bias_d;
  logic                          avg_en_q, avg_en_d;
  logic                          win_en_q, win_en_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    dc_bias_d = dc_bias_q;
    avg_en_d  = avg_en_q;
    win_en_d  = win_en_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        afow_pkg::CFG_IDX_DC_BIAS: dc_bias_d = cfg_data_i[afow_pkg::SAMPLE_W-1:0];
        afow_pkg::CFG_IDX_AVG_EN:  avg_en_d  = cfg_data_i[0];
        afow_pkg::CFG_IDX_WIN_EN:  win_en_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_bias_q <= afow_pkg::DC_BIAS_RST;
      avg_en_q  <= 1'b0;
      win_en_q  <= 1'b0;
    end else begin
      dc_bias_q <= dc_bias_d;
      avg_en_q  <= avg_en_d;
      win_en_q  <= win_en_d;
    end
  end

  // Front end.
  logic                      push;
  logic                      q_full;
  logic                      q_empty;
  logic                      pop;
  afow_pkg::cls_t            fr_cls;
  logic [FIDX_W-1:0]         fr_f;
  logic signed [LEVEL_W-1:0] fr_cur;
  logic [ENT_W-1:0]          q_wdata;
  logic [ENT_W-1:0]          q_rdata;
  afow_pkg::cls_t            hd_cls;
  logic [FIDX_W-1:0]         hd_f;
  logic signed [LEVEL_W-1:0] hd_cur;

  afow_front #(
    .FRAME_LEN (FRAME_LEN),
    .FFT_LEN   (FFT_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .dc_bias_i    (dc_bias_q),
    .full_i       (q_full),
    .push_o       (push),
    .cls_o        (fr_cls),
    .f_o          (fr_f),
    .cur_o        (fr_cur)
  );

  // Queue between the two halves.
  assign q_wdata = {fr_cls, fr_f, fr_cur};

  afow_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign hd_cls = q_rdata[ENT_W-1 -: CLS_W];
  assign hd_f   = q_rdata[LEVEL_W +: FIDX_W];
  assign hd_cur = q_rdata[LEVEL_W-1:0];

  // Back end.
  afow_back #(
    .FRAME_LEN (FRAME_LEN),
    .FFT_LEN   (FFT_LEN)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .head_cls_i       (hd_cls),
    .head_f_i         (hd_f),
    .head_cur_i       (hd_cur),
    .average_enable_i (avg_en_q),
    .window_enable_i  (win_en_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .position_o       (position_o),
    .level_o          (level_o),
    .frame_last_o     (frame_last_o)
  );

endmodule

FILE: hw/rtl/afow_front.sv
// ----------------------------------------------------------------------------
// Overlap window framer front end
// Accepts raw samples, removes the bias, tracks the frame index and tags each
// word with what the back end must do with it.
// ----------------------------------------------------------------------------
module afow_front #(
  parameter int FRAME_LEN = 736,
  parameter int FFT_LEN   = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [afow_pkg::SAMPLE_W-1:0]        raw_sample_i,
  input  logic [afow_pkg::SAMPLE_W-1:0]        dc_bias_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output afow_pkg::cls_t                       cls_o,
  output logic [$clog2(FRAME_LEN)-1:0]         f_o,
  output logic signed [afow_pkg::LEVEL_W-1:0]  cur_o
);

  localparam int FIDX_W    = $clog2(FRAME_LEN);
  localparam int OVERLAP   = afow_pkg::overlap_len(FRAME_LEN, FFT_LEN);
  localparam int SKIP      = afow_pkg::skip_len(FRAME_LEN, FFT_LEN);
  localparam int TAIL_BASE = FRAME_LEN - OVERLAP;

  localparam logic [FIDX_W:0]   OVL_C  = (FIDX_W + 1)'(OVERLAP);
  localparam logic [FIDX_W:0]   SKIP_C = (FIDX_W + 1)'(SKIP);
  localparam logic [FIDX_W:0]   BASE_C = (FIDX_W + 1)'(TAIL_BASE);
  localparam logic [FIDX_W-1:0] LAST_C = FIDX_W'(FRAME_LEN - 1);

  logic [FIDX_W-1:0] f_q, f_d;
  logic              seen_q, seen_d;
  logic              accept;
  logic              f_last;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept;
  assign f_last     = (f_q == LAST_C);

  // Classify the word by its place in the frame.
  always_comb begin
    cls_o.seen     = seen_q;
    cls_o.has_tail = ({1'b0, f_q} < OVL_C);
    cls_o.has_new  = ({1'b0, f_q} >= SKIP_C);
    cls_o.tail_wr  = ({1'b0, f_q} >= BASE_C);
    cls_o.last     = f_last;
  end

  // Bias removal; the difference always fits in the signed level width.
  assign cur_o = $signed({1'b0, raw_sample_i}) - $signed({1'b0, dc_bias_i});
  assign f_o   = f_q;

  // Frame index and first-frame flag advance on every accepted word.
  always_comb begin
    f_d    = f_q;
    seen_d = seen_q;
    if (accept) begin
      f_d    = f_last ? '0 : f_q + 1'b1;
      seen_d = seen_q | f_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q    <= '0;
      seen_q <= 1'b0;
    end else begin
      f_q    <= f_d;
      seen_q <= seen_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The index wraps after the last sample of a frame and marks the stores live.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && f_last |=> (f_q == '0) && seen_q)
    else $error("frame index did not wrap after the last sample");
`endif

endmodule

FILE: hw/rtl/afow_queue.sv
// ----------------------------------------------------------------------------
// Overlap window framer queue
// Two-entry register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module afow_queue #(
  parameter int WIDTH = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wptr_d  = push_i ? ~wptr_q : wptr_q;
    rptr_d  = pop_i ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The back end never takes a word from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("queue read while empty");

  // The front end never writes a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2) || pop_i)
    else $error("queue written while full");
`endif

endmodule

FILE: hw/rtl/afow_back.sv
// ----------------------------------------------------------------------------
// Overlap window framer back end
// Reads the previous-frame and overlap stores, averages, keeps the overlap
// tail, windows each result with the Hann table and drives the output word.
// ----------------------------------------------------------------------------
module afow_back #(
  parameter int FRAME_LEN = 736,
  parameter int FFT_LEN   = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  output logic                                 pop_o,
  input  afow_pkg::cls_t                       head_cls_i,
  input  logic [$clog2(FRAME_LEN)-1:0]         head_f_i,
  input  logic signed [afow_pkg::LEVEL_W-1:0]  head_cur_i,
  input  logic                                 average_enable_i,
  input  logic                                 window_enable_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [afow_pkg::POS_W-1:0]           position_o,
  output logic signed [afow_pkg::LEVEL_W-1:0]  level_o,
  output logic                                 frame_last_o
);

  localparam int LEVEL_W    = afow_pkg::LEVEL_W;
  localparam int COEF_W     = afow_pkg::COEF_W;
  localparam int POS_W      = afow_pkg::POS_W;
  localparam int FIDX_W     = $clog2(FRAME_LEN);
  localparam int PPOS_W     = $clog2(FFT_LEN);
  localparam int ROM_DEPTH  = 1 << PPOS_W;
  localparam int OVERLAP    = afow_pkg::overlap_len(FRAME_LEN, FFT_LEN);
  localparam int SKIP       = afow_pkg::skip_len(FRAME_LEN, FFT_LEN);
  localparam int TAIL_BASE  = FRAME_LEN - OVERLAP;
  localparam int TAIL_DEPTH = (OVERLAP > 0) ? OVERLAP : 1;
  localparam int TIDX_W     = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
  localparam int CALC_W     = ((FIDX_W > PPOS_W) ? FIDX_W : PPOS_W) + 1;
  localparam int PROD_W     = LEVEL_W + COEF_W + 1;

  localparam longint unsigned SPAN = longint'(FFT_LEN - 1);

  // --------------------------------------------------------------------------
  // Hann coefficient table, built at elaboration: sin^2 by a Taylor series.
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0] hann_rom [ROM_DEPTH];

  for (genvar p = 0; p < ROM_DEPTH; p++) begin : g_rom
    localparam longint unsigned PL = longint'(p);
    localparam longint unsigned TT = (PL <= SPAN - PL) ? PL : SPAN - PL;
    localparam longint unsigned XX = (afow_pkg::PI_Q30 * TT) / SPAN;
    localparam longint unsigned X2 = (XX * XX) >> 30;
    localparam longint unsigned T1 = ((XX * X2) / 6) >> 30;
    localparam longint unsigned T2 = ((T1 * X2) / 20) >> 30;
    localparam longint unsigned T3 = ((T2 * X2) / 42) >> 30;
    localparam longint unsigned T4 = ((T3 * X2) / 72) >> 30;
    localparam longint unsigned T5 = ((T4 * X2) / 110) >> 30;
    localparam longint SUM = longint'(XX) - longint'(T1) + longint'(T2)
                           - longint'(T3) + longint'(T4) - longint'(T5);
    localparam longint unsigned SCL = (SUM < 0) ? 64'd0 :
      ((SUM > longint'(afow_pkg::ONE_Q30)) ? afow_pkg::ONE_Q30 : longint'(SUM));
    localparam longint unsigned CSQ  = (SCL * SCL) >> 45;
    localparam longint unsigned COEF = (p < FFT_LEN) ?
      ((CSQ > afow_pkg::COEF_MAX) ? afow_pkg::COEF_MAX : CSQ) : 64'd0;
    assign hann_rom[p] = COEF_W'(COEF);
  end

  // --------------------------------------------------------------------------
  // Stage 1: word taken from the queue, stores and table read.
  // --------------------------------------------------------------------------
  logic signed [LEVEL_W-1:0] prev_mem [FRAME_LEN];
  logic signed [LEVEL_W-1:0] tail_mem [TAIL_DEPTH];

  logic                      s1_valid_q, s1_valid_d;
  afow_pkg::cls_t            s1_cls_q;
  logic [FIDX_W-1:0]         s1_f_q;
  logic signed [LEVEL_W-1:0] s1_cur_q;
  logic [PPOS_W-1:0]         s1_pos_tail_q;
  logic [PPOS_W-1:0]         s1_pos_new_q;
  logic signed [LEVEL_W-1:0] prev_rd_q;
  logic signed [LEVEL_W-1:0] tail_rd_q;
  logic [COEF_W-1:0]         coef_tail_q;
  logic [COEF_W-1:0]         coef_new_q;
  logic                      fwd_q;
  logic signed [LEVEL_W-1:0] fwd_data_q;

  logic [PPOS_W-1:0]         head_pos_tail;
  logic [CALC_W-1:0]         head_pos_wide;
  logic [PPOS_W-1:0]         head_pos_new;
  logic [TIDX_W-1:0]         head_tidx;
  logic                      s1_adv;
  logic                      s2_free;
  logic                      fwd_d;

  // Frame positions of the head word's two possible results.
  assign head_pos_tail = PPOS_W'(head_f_i);
  assign head_pos_wide = CALC_W'(OVERLAP) + CALC_W'(head_f_i) - CALC_W'(SKIP);
  assign head_pos_new  = head_pos_wide[PPOS_W-1:0];
  assign head_tidx     = head_f_i[TIDX_W-1:0];

  assign s1_adv     = s1_valid_q & s2_free;
  assign pop_o      = ~empty_i & (~s1_valid_q | s1_adv);
  assign s1_valid_d = pop_o | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cls_q      <= head_cls_i;
      s1_f_q        <= head_f_i;
      s1_cur_q      <= head_cur_i;
      s1_pos_tail_q <= head_pos_tail;
      s1_pos_new_q  <= head_pos_new;
      coef_tail_q   <= hann_rom[head_pos_tail];
      coef_new_q    <= hann_rom[head_pos_new];
    end
  end

  // --------------------------------------------------------------------------
  // Averaging and store update, done as the word moves to stage 2.
  // --------------------------------------------------------------------------
  logic signed [LEVEL_W-1:0] prev_val;
  logic signed [LEVEL_W:0]   avg_sum;
  logic signed [LEVEL_W:0]   avg_adj;
  logic signed [LEVEL_W-1:0] proc;
  logic signed [LEVEL_W-1:0] tail_val;
  logic [FIDX_W-1:0]         tail_wr_full;
  logic [TIDX_W-1:0]         tail_widx;

  // Stores read as zero until a full frame has been written.
  assign prev_val = s1_cls_q.seen ? prev_rd_q : '0;
  assign tail_val = fwd_q ? fwd_data_q : (s1_cls_q.seen ? tail_rd_q : '0);

  // Halve the sum, truncating toward zero.
  assign avg_sum = {s1_cur_q[LEVEL_W-1], s1_cur_q} + {prev_val[LEVEL_W-1], prev_val};
  assign avg_adj = avg_sum + (LEVEL_W + 1)'(avg_sum[LEVEL_W]);
  assign proc    = average_enable_i ? avg_adj[LEVEL_W:1] : s1_cur_q;

  assign tail_wr_full = s1_f_q - FIDX_W'(TAIL_BASE);
  assign tail_widx    = tail_wr_full[TIDX_W-1:0];

  // A tail entry written in the same cycle that the next word reads it.
  assign fwd_d = s1_adv & s1_cls_q.tail_wr & (tail_widx == head_tidx);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fwd_q      <= fwd_d;
      fwd_data_q <= proc;
    end
  end

  // Previous-frame store: one write and one read port.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      prev_mem[s1_f_q] <= s1_cur_q;
    end
    if (pop_o) begin
      prev_rd_q <= prev_mem[head_f_i];
    end
  end

  // Overlap tail store: one write and one read port.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_cls_q.tail_wr) begin
      tail_mem[tail_widx] <= proc;
    end
    if (pop_o) begin
      tail_rd_q <= tail_mem[head_tidx];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: up to two pending results, tail first.
  // --------------------------------------------------------------------------
  logic                      tail_pend_q, tail_pend_d;
  logic                      new_pend_q, new_pend_d;
  logic signed [LEVEL_W-1:0] tail_level_q, new_level_q;
  logic [PPOS_W-1:0]         tail_pos_q, new_pos_q;
  logic [COEF_W-1:0]         tail_coef_q, new_coef_q;
  logic                      new_last_q;
  logic                      out_load;
  logic                      emit;

  assign out_load = ~out_valid_o | out_ready_i;
  assign emit     = (tail_pend_q | new_pend_q) & out_load;
  assign s2_free  = ~(tail_pend_q | new_pend_q) | (emit & ~(tail_pend_q & new_pend_q));

  always_comb begin
    tail_pend_d = tail_pend_q;
    new_pend_d  = new_pend_q;
    if (s1_adv) begin
      tail_pend_d = s1_cls_q.has_tail;
      new_pend_d  = s1_cls_q.has_new;
    end else if (emit) begin
      if (tail_pend_q) begin
        tail_pend_d = 1'b0;
      end else begin
        new_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_pend_q <= 1'b0;
      new_pend_q  <= 1'b0;
    end else begin
      tail_pend_q <= tail_pend_d;
      new_pend_q  <= new_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      tail_level_q <= tail_val;
      tail_pos_q   <= s1_pos_tail_q;
      tail_coef_q  <= coef_tail_q;
      new_level_q  <= proc;
      new_pos_q    <= s1_pos_new_q;
      new_coef_q   <= coef_new_q;
      new_last_q   <= s1_cls_q.last;
    end
  end

  // --------------------------------------------------------------------------
  // Windowing multiply and output register.
  // --------------------------------------------------------------------------
  logic signed [LEVEL_W-1:0] sel_level;
  logic [COEF_W-1:0]         sel_coef;
  logic [PPOS_W-1:0]         sel_pos;
  logic                      sel_last;
  logic signed [PROD_W-1:0]  prod;
  logic signed [LEVEL_W-1:0] win_level;

  logic                      out_valid_q, out_valid_d;
  logic [POS_W-1:0]          position_q;
  logic signed [LEVEL_W-1:0] level_q;
  logic                      last_q;

  assign sel_level = tail_pend_q ? tail_level_q : new_level_q;
  assign sel_coef  = tail_pend_q ? tail_coef_q : new_coef_q;
  assign sel_pos   = tail_pend_q ? tail_pos_q : new_pos_q;
  assign sel_last  = tail_pend_q ? 1'b0 : new_last_q;

  // Q15 product, floor of the shift by the arithmetic right shift.
  assign prod      = sel_level * $signed({1'b0, sel_coef});
  assign win_level = window_enable_i ? prod[afow_pkg::COEF_FRAC +: LEVEL_W] : sel_level;

  assign out_valid_d = out_load ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      position_q <= POS_W'(sel_pos);
      level_q    <= win_level;
      last_q     <= sel_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = position_q;
  assign level_o      = level_q;
  assign frame_last_o = last_q;

`ifndef NO_ASSERTIONS
  // The frame closes only at the last position of the FFT frame.
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> (position_o == POS_W'(FFT_LEN - 1)))
    else $error("frame end flagged away from the last position");

  // A word never moves into stage 2 over two pending results.
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> !(tail_pend_q && new_pend_q))
    else $error("stage 2 results overwritten");
`endif

endmodule

FILE: sim/afow_frame_checker.sv
// ----------------------------------------------------------------------------
// Overlap window framer checker
// Watches the sample, result and register channels of the framer. It keeps
// its own copy of the bias, averaging and window settings, of both sample
// stores and of the frame position. From these it predicts the result words
// of every accepted sample, and it compares each accepted result word field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module afow_frame_checker #(
  parameter int FRAME_LEN = 736,
  parameter int FFT_LEN   = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [afow_pkg::SAMPLE_W-1:0]        raw_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [afow_pkg::POS_W-1:0]           position_i,
  input  logic signed [afow_pkg::LEVEL_W-1:0]  level_i,
  input  logic                                 frame_last_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [afow_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [afow_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output int                                   mismatch_count_o,
  output int                                   pending_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = afow_pkg::SAMPLE_W;
  localparam int POS_W    = afow_pkg::POS_W;
  localparam int LEVEL_W  = afow_pkg::LEVEL_W;
  localparam int COEF_W   = afow_pkg::COEF_W;

  // Frame geometry: samples carried over, and new samples that fall outside.
  localparam int RAW_TAIL = (FFT_LEN > FRAME_LEN) ? (FFT_LEN - FRAME_LEN) : 0;
  localparam int TAIL_LEN = (RAW_TAIL > FRAME_LEN) ? FRAME_LEN : RAW_TAIL;
  localparam int SKIP_LEN = (FRAME_LEN > FFT_LEN) ? (FRAME_LEN - FFT_LEN) : 0;

  typedef struct {
    logic [POS_W-1:0]          position;
    logic signed [LEVEL_W-1:0] level;
    logic                      frame_last;
  } frame_word_t;

  frame_word_t               expected_words[$];

  // Mirrored settings and stores.
  logic [SAMPLE_W-1:0]       bias_q;
  logic                      avg_en_q;
  logic                      win_en_q;
  logic signed [LEVEL_W-1:0] prev_frame_mem [FRAME_LEN];
  logic signed [LEVEL_W-1:0] tail_mem [TAIL_LEN+1];
  int                        frame_pos;
  logic [COEF_W-1:0]         hann_coefs [FFT_LEN];

  // Q15 Hann coefficient, squared Taylor sine in Q30 with floor at each step.
  function automatic logic [COEF_W-1:0] hann_q15(input int unsigned p);
    longint unsigned span;
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned c;
    longint          sum;
    int              k;
    span = longint'(FFT_LEN) - 1;
    if (span == 0 || p > span) begin
      return '0;
    end
    t = (p <= span - p) ? p : span - p;
    x = (afow_pkg::PI_Q30 * t) / span;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (k = 1; k <= 5; k++) begin
      term = (term * x2) / longint'((2 * k) * (2 * k + 1));
      term = term >> 30;
      if (k % 2 == 1) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = sum;
    if (s > afow_pkg::ONE_Q30) begin
      s = afow_pkg::ONE_Q30;
    end
    c = (s * s) >> 45;
    if (c > afow_pkg::COEF_MAX) begin
      c = afow_pkg::COEF_MAX;
    end
    return c[COEF_W-1:0];
  endfunction

  initial begin
    for (int p = 0; p < FFT_LEN; p++) begin
      hann_coefs[p] = hann_q15(p);
    end
  end

  // Windowed level; the arithmetic shift gives floor rounding.
  function automatic logic signed [LEVEL_W-1:0] shape_level(
    input logic signed [LEVEL_W-1:0] v,
    input int unsigned               pos
  );
    longint prod;
    if (!win_en_q) begin
      return v;
    end
    if (pos >= FFT_LEN) begin
      return '0;
    end
    prod = longint'(v) * longint'(hann_coefs[pos]);
    prod = prod >>> afow_pkg::COEF_FRAC;
    return prod[LEVEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns afow check: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Works out the result words, up to two, that a new sample causes.
  task automatic predict_frame_words(input logic [SAMPLE_W-1:0] raw);
    int          f;
    int          cur;
    int          proc;
    int unsigned pos;
    frame_word_t w;
    f = frame_pos;
    if (f >= FRAME_LEN) begin
      f = 0;
    end
    cur = int'(raw) - int'(bias_q);
    if (avg_en_q) begin
      proc = (cur + int'(prev_frame_mem[f])) / 2;
    end else begin
      proc = cur;
    end
    prev_frame_mem[f] = cur[LEVEL_W-1:0];
    // The old tail sample goes out first during the overlap part.
    if (f < TAIL_LEN) begin
      w.position   = f[POS_W-1:0];
      w.level      = shape_level(tail_mem[f], f);
      w.frame_last = 1'b0;
      expected_words.push_back(w);
    end
    if (f >= FRAME_LEN - TAIL_LEN) begin
      tail_mem[f - (FRAME_LEN - TAIL_LEN)] = proc[LEVEL_W-1:0];
    end
    if (f >= SKIP_LEN) begin
      pos          = TAIL_LEN + f - SKIP_LEN;
      w.position   = pos[POS_W-1:0];
      w.level      = shape_level(proc[LEVEL_W-1:0], pos);
      w.frame_last = (f == FRAME_LEN - 1);
      expected_words.push_back(w);
    end
    f++;
    if (f >= FRAME_LEN) begin
      f = 0;
    end
    frame_pos = f;
  endtask

  task automatic check_result_word();
    frame_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("result word at position %0d with none expected",
                                position_i));
      return;
    end
    w = expected_words.pop_front();
    if (position_i !== w.position) begin
      report_mismatch($sformatf("position %0d, expected %0d", position_i, w.position));
    end
    if (level_i !== w.level) begin
      report_mismatch($sformatf("level %0d at position %0d, expected %0d",
                                level_i, w.position, w.level));
    end
    if (frame_last_i !== w.frame_last) begin
      report_mismatch($sformatf("frame_last %0b at position %0d, expected %0b",
                                frame_last_i, w.position, w.frame_last));
    end
  endtask

  // Channel monitor: results are checked before new samples are predicted.
  always @(posedge clk_i or negedge rst_ni) begin : track
    if (!rst_ni) begin
      bias_q    = afow_pkg::DC_BIAS_RST;
      avg_en_q  = 1'b0;
      win_en_q  = 1'b0;
      frame_pos = 0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        prev_frame_mem[i] = '0;
      end
      for (int i = 0; i <= TAIL_LEN; i++) begin
        tail_mem[i] = '0;
      end
      expected_words.delete();
      pending_count_o  = 0;
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result_word();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          afow_pkg::CFG_IDX_DC_BIAS: bias_q = cfg_data_i[SAMPLE_W-1:0];
          afow_pkg::CFG_IDX_AVG_EN:  avg_en_q = cfg_data_i[0];
          afow_pkg::CFG_IDX_WIN_EN:  win_en_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_frame_words(raw_sample_i);
      end
      pending_count_o = expected_words.size();
    end
  end

endmodule

FILE: sim/audio_frame_overlap_window_unit_tb.sv
// ----------------------------------------------------------------------------
// Audio frame overlap window unit testbench
// Drives raw samples and register writes into the framer with random gaps
// on both channels, a long output hold-off and a full drain, while the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module audio_frame_overlap_window_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = afow_pkg::SAMPLE_W;
  localparam int POS_W      = afow_pkg::POS_W;
  localparam int LEVEL_W    = afow_pkg::LEVEL_W;
  localparam int CFG_IDX_W  = afow_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = afow_pkg::CFG_DATA_W;

  localparam int FRAME_LEN = 736;
  localparam int FFT_LEN   = 1024;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 100;
  localparam int HOLD_LEN  = 300;

  // Index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [SAMPLE_W-1:0]       raw_sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [POS_W-1:0]          position_o;
  logic signed [LEVEL_W-1:0] level_o;
  logic                      frame_last_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  int                        mismatch_total;
  int                        words_pending;
  int                        rx_hold_cycles;
  bit                        rx_steady;
  bit                        tx_steady;
  logic [SAMPLE_W-1:0]       cur_bias;

  audio_frame_overlap_window_unit #(
    .FRAME_LEN (FRAME_LEN),
    .FFT_LEN   (FFT_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .position_o   (position_o),
    .level_o      (level_o),
    .frame_last_o (frame_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  afow_frame_checker #(
    .FRAME_LEN (FRAME_LEN),
    .FFT_LEN   (FFT_LEN)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .raw_sample_i     (raw_sample_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .position_i       (position_o),
    .level_i          (level_o),
    .frame_last_i     (frame_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_total),
    .pending_count_o  (words_pending)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Raw sample with extra weight on the rails and the area around the bias.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return cur_bias;
      3: return cur_bias + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
      default: return SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Offers one sample word after an optional gap and waits for its acceptance.
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic stop_samples();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (words_pending != 0) @(negedge clk_i);
  endtask

  // One register word; valid stays high so writes can follow back to back.
  task automatic cfg_write_word(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all registers, only with the block drained; the enables use bit 0.
  task automatic set_config(input logic [CFG_DATA_W-1:0] bias,
                            input logic [CFG_DATA_W-1:0] avg_data,
                            input logic [CFG_DATA_W-1:0] win_data,
                            input bit                    stray);
    wait_drained();
    cfg_write_word(afow_pkg::CFG_IDX_DC_BIAS, bias);
    cfg_write_word(afow_pkg::CFG_IDX_AVG_EN, avg_data);
    cfg_write_word(afow_pkg::CFG_IDX_WIN_EN, win_data);
    if (stray) begin
      cfg_write_word(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 4095)));
    end
    cur_bias = bias;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Result receiver: random stalls, steady stretches and requested hold-offs.
  initial begin : receiver
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        n = idle_len();
        if (rx_steady || n == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] bias;
    in_valid_i     = 1'b0;
    raw_sample_i   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    rx_hold_cycles = 0;
    rx_steady      = 1'b0;
    tx_steady      = 1'b0;
    cur_bias       = afow_pkg::DC_BIAS_RST;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: rails, bias point and alternating bit patterns.
    push_sample(12'd0, 0);
    push_sample(12'd4095, 0);
    push_sample(12'd2048, 1);
    push_sample(12'd2047, 0);
    push_sample(12'd2049, 2);
    push_sample(12'h555, 0);
    push_sample(12'haaa, 0);
    stop_samples();

    // Zero bias with averaging against the previous frame.
    set_config(12'd0, 12'd1, 12'd0, 1'b0);
    push_sample(12'd4095, 0);
    push_sample(12'd0, 0);
    push_sample(12'd1, 0);
    stop_samples();

    // Full-scale bias with the window on: most negative levels.
    set_config(12'd4095, 12'd0, 12'd1, 1'b0);
    push_sample(12'd0, 0);
    push_sample(12'd4095, 0);
    push_sample(12'd2048, 0);
    stop_samples();

    // Both averaging and window, plus a write past the register list.
    set_config(12'd2048, 12'd1, 12'd1, 1'b1);
    push_sample(12'd0, 0);
    push_sample(12'd4095, 0);
    push_sample(12'd3000, 0);
    push_sample(12'd100, 0);
    stop_samples();

    // Enables ignore all but their low bit.
    set_config(12'd1, 12'hffe, 12'hfff, 1'b0);
    push_sample(12'd0, 0);
    push_sample(12'd4095, 0);
    stop_samples();

    // Random phases, each with fresh settings taken mid frame.
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: bias = 12'd0;
        1: bias = 12'd4095;
        2: bias = 12'd2048;
        default: bias = CFG_DATA_W'($urandom_range(0, 4095));
      endcase
      set_config(bias, CFG_DATA_W'($urandom_range(0, 4095)),
                 CFG_DATA_W'($urandom_range(0, 4095)), $urandom_range(0, 3) == 0);
      rx_steady = (ph == 4);
      tx_steady = (ph == 4) || (ph == 2);
      // The receiver holds off while samples keep coming, so the block backs up.
      if (ph == 2) begin
        rx_hold_cycles = HOLD_LEN;
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        // The sender pauses until every result of this phase so far is out.
        if (ph == 6 && i == PHASE_LEN / 2) begin
          stop_samples();
          wait_drained();
        end
        push_sample(pick_sample(), tx_steady ? 0 : idle_len());
      end
      stop_samples();
    end
    rx_steady = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_total == 0 && words_pending == 0) begin
      $display("audio_frame_overlap_window_unit_tb: PASS");
    end else begin
      $display("audio_frame_overlap_window_unit_tb: FAIL");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("audio_frame_overlap_window_unit_tb: FAIL");
    $finish;
  end

endmodule
